FILE: design/h264fua_pkg.sv
package h264fua_pkg;

	localparam int unsigned LEN_BITS = 24;
	localparam int unsigned LIM_BITS = 14;
	localparam int unsigned MAX_RESULTS = 3;

	localparam logic [LIM_BITS-1:0] LIMIT_RESET = 14'd1400;
	localparam logic [LIM_BITS-1:0] LIMIT_FLOOR = 14'd3;
	localparam logic [LIM_BITS-1:0] FU_OVERHEAD = 14'd2;

	localparam logic [4:0] FU_A_TYPE = 5'd28;
	localparam logic [7:0] NRI_MASK = 8'h60;
	localparam logic [7:0] TYPE_MASK = 8'h1F;

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'b0001,
		MODE_SINGLE = 4'b0010,
		MODE_FRAG   = 4'b0100,
		MODE_DROP   = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
		logic       marker;
		logic       run_end;
	} res_t;

endpackage

FILE: design/h264_nal_fu_a_packetizer.sv
// H.264 NAL unit packetizer with FU-A fragmentation. NAL unit bytes enter one beat at a
// time, header byte first, with the unit length and key-frame flag given on the header
// beat. Units up to max_payload_size bytes leave unchanged as one packet; longer units
// leave as FU-A fragments with an FU indicator and FU header ahead of up to
// max_payload_size - 2 payload bytes. Non-key units are dropped until the first packet
// has gone out. Each input beat is decoded in its accept cycle into up to three output
// beats held in a small result register, which drains one beat per cycle while out_ready
// is high and takes the next input beat in the same cycle its last beat leaves. Ordinary
// bytes pass at one beat per cycle while the output is not stalled, the header beat of a
// fragmented unit yields no output, and the first byte of each fragment leaves behind its
// FU indicator and FU header. Write max_payload_size only while no beats are in flight.
module h264_nal_fu_a_packetizer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [h264fua_pkg::LIM_BITS-1:0]  max_payload_size,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	input  logic                              first_of_unit,
	input  logic [h264fua_pkg::LEN_BITS-1:0]  unit_length,
	input  logic                              key_frame,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        out_byte,
	output logic                              packet_first,
	output logic                              packet_last,
	output logic                              rtp_marker,
	output logic                              last_of_run
);

	localparam int unsigned LB = h264fua_pkg::LEN_BITS;
	localparam int unsigned MB = h264fua_pkg::LIM_BITS;

	logic [MB-1:0]              limit_q;
	h264fua_pkg::mode_t         mode_q, mode_d;
	logic [LB-1:0]              unit_left_q, unit_left_d;
	logic [MB-1:0]              frag_left_q, frag_left_d;
	logic [1:0]                 nri_q, nri_d;
	logic [4:0]                 ntype_q, ntype_d;
	logic                       first_frag_q, first_frag_d;
	logic                       sent_q, sent_d;

	h264fua_pkg::res_t          res_s1 [h264fua_pkg::MAX_RESULTS];
	h264fua_pkg::res_t          res_d  [h264fua_pkg::MAX_RESULTS];
	logic [1:0]                 cnt_s1, cnt_d;

	logic                       in_acc, out_acc;
	logic [MB-1:0]              eff_lim, cap, plen;
	logic [LB-1:0]              len_eff;
	logic                       fits_cap, end_frag;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = (cnt_s1 != 2'd0);
	assign out_acc   = out_valid && out_ready;
	assign in_ready  = (cnt_s1 == 2'd0) || ((cnt_s1 == 2'd1) && out_ready);

	assign out_byte     = res_s1[0].data;
	assign packet_first = res_s1[0].first;
	assign packet_last  = res_s1[0].last;
	assign rtp_marker   = res_s1[0].marker;
	assign last_of_run  = res_s1[0].run_end;

	assign eff_lim  = (limit_q < h264fua_pkg::LIMIT_FLOOR) ? h264fua_pkg::LIMIT_FLOOR : limit_q;
	assign cap      = eff_lim - h264fua_pkg::FU_OVERHEAD;
	assign fits_cap = (unit_left_q <= {{(LB-MB){1'b0}}, cap});
	assign plen     = fits_cap ? unit_left_q[MB-1:0] : cap;
	assign end_frag = fits_cap;
	assign len_eff  = (unit_length == '0) ? {{(LB-1){1'b0}}, 1'b1} : unit_length;

	always_comb begin
		mode_d       = mode_q;
		unit_left_d  = unit_left_q;
		frag_left_d  = frag_left_q;
		nri_d        = nri_q;
		ntype_d      = ntype_q;
		first_frag_d = first_frag_q;
		sent_d       = sent_q;
		cnt_d        = 2'd0;
		for (int i = 0; i < h264fua_pkg::MAX_RESULTS; i++) begin
			res_d[i] = '0;
		end
		if (first_of_unit) begin
			unit_left_d = len_eff - {{(LB-1){1'b0}}, 1'b1};
			frag_left_d = '0;
			if (!sent_q && !key_frame) begin
				mode_d = h264fua_pkg::MODE_DROP;
			end else if (len_eff <= {{(LB-MB){1'b0}}, eff_lim}) begin
				mode_d   = (unit_left_d != '0) ? h264fua_pkg::MODE_SINGLE : h264fua_pkg::MODE_IDLE;
				res_d[0] = '{data: data_byte, first: 1'b1,
					last: (len_eff == {{(LB-1){1'b0}}, 1'b1}), marker: 1'b1, run_end: 1'b1};
				cnt_d    = 2'd1;
				sent_d   = 1'b1;
			end else begin
				nri_d        = data_byte[6:5];
				ntype_d      = data_byte[4:0];
				first_frag_d = 1'b1;
				mode_d       = h264fua_pkg::MODE_FRAG;
			end
		end else begin
			unique case (mode_q)
				h264fua_pkg::MODE_SINGLE: begin
					unit_left_d = unit_left_q - {{(LB-1){1'b0}}, 1'b1};
					res_d[0]    = '{data: data_byte, first: 1'b0,
						last: (unit_left_d == '0), marker: 1'b1, run_end: 1'b1};
					cnt_d       = 2'd1;
					if (unit_left_d == '0) begin
						mode_d = h264fua_pkg::MODE_IDLE;
					end
				end
				h264fua_pkg::MODE_FRAG: begin
					unit_left_d = unit_left_q - {{(LB-1){1'b0}}, 1'b1};
					if (frag_left_q == '0) begin
						res_d[0] = '{data: {1'b0, nri_q, h264fua_pkg::FU_A_TYPE}, first: 1'b1,
							last: 1'b0, marker: end_frag, run_end: 1'b0};
						res_d[1] = '{data: {first_frag_q, end_frag, 1'b0, ntype_q}, first: 1'b0,
							last: 1'b0, marker: end_frag, run_end: 1'b0};
						res_d[2] = '{data: data_byte, first: 1'b0,
							last: (plen == {{(MB-1){1'b0}}, 1'b1}), marker: end_frag,
							run_end: 1'b1};
						frag_left_d  = plen - {{(MB-1){1'b0}}, 1'b1};
						first_frag_d = 1'b0;
						sent_d       = 1'b1;
						cnt_d        = 2'd3;
					end else begin
						res_d[0] = '{data: data_byte, first: 1'b0,
							last: (frag_left_q == {{(MB-1){1'b0}}, 1'b1}),
							marker: ({{(LB-MB){1'b0}}, frag_left_q} == unit_left_q),
							run_end: 1'b1};
						frag_left_d = frag_left_q - {{(MB-1){1'b0}}, 1'b1};
						cnt_d       = 2'd1;
					end
					if (unit_left_d == '0) begin
						mode_d = h264fua_pkg::MODE_IDLE;
					end
				end
				h264fua_pkg::MODE_DROP: begin
					if (unit_left_q != '0) begin
						unit_left_d = unit_left_q - {{(LB-1){1'b0}}, 1'b1};
					end
					if (unit_left_d == '0) begin
						mode_d = h264fua_pkg::MODE_IDLE;
					end
				end
				h264fua_pkg::MODE_IDLE: begin
					mode_d = h264fua_pkg::MODE_IDLE;
				end
				default: begin
					mode_d = h264fua_pkg::MODE_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q      <= h264fua_pkg::LIMIT_RESET;
			mode_q       <= h264fua_pkg::MODE_IDLE;
			unit_left_q  <= '0;
			frag_left_q  <= '0;
			nri_q        <= '0;
			ntype_q      <= '0;
			first_frag_q <= 1'b0;
			sent_q       <= 1'b0;
			cnt_s1       <= 2'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= max_payload_size;
			end
			if (in_acc) begin
				mode_q       <= mode_d;
				unit_left_q  <= unit_left_d;
				frag_left_q  <= frag_left_d;
				nri_q        <= nri_d;
				ntype_q      <= ntype_d;
				first_frag_q <= first_frag_d;
				sent_q       <= sent_d;
				cnt_s1       <= cnt_d;
			end else if (out_acc) begin
				cnt_s1 <= cnt_s1 - 2'd1;
			end
		end
	end

	// advance the result queue by one beat, or reload it from the decoder
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < h264fua_pkg::MAX_RESULTS; i++) begin
				res_s1[i] <= res_d[i];
			end
		end else if (out_acc) begin
			for (int i = 0; i < h264fua_pkg::MAX_RESULTS - 1; i++) begin
				res_s1[i] <= res_s1[i+1];
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_s1 == 2'd2 || cnt_s1 == 2'd3) |-> !in_ready)
		else $error("input taken while result queue holds several beats");

	a_run_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_of_run) |-> (cnt_s1 == 2'd1))
		else $error("run end flag not on final queued beat");

	a_fu_indicator: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_s1 == 2'd3) |-> (packet_first && !packet_last && !last_of_run))
		else $error("fragment start does not lead with FU indicator");

	a_sent_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(sent_q))
		else $error("sent flag cleared outside reset");
`endif

endmodule
